/* hw/rtl/bsp_pkg.sv */
// Shared types and constants for the 2D cubic Bezier spline evaluator.
package bsp_pkg;

  localparam int COORD_W = 24;
  localparam int TPAR_W  = 17;
  localparam int SIX_W   = 19;
  localparam int COEF_W  = 34;
  localparam int WT_W    = 33;
  localparam int OUT_W   = 32;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [TPAR_W-1:0]         tpar_t;
  typedef logic [SIX_W-1:0]          six_t;
  typedef logic signed [OUT_W-1:0]   res_t;

  // per-stage load enables
  typedef struct packed {
    logic st1;
    logic st2;
    logic st3;
    logic st4;
    logic st5;
    logic st6;
  } pipe_en_t;

  // derivative coefficients 3*u*u, 6*u*t, 3*t*t (Q2.32)
  typedef struct packed {
    logic [COEF_W-1:0] cu;
    logic [COEF_W-1:0] cm;
    logic [COEF_W-1:0] ct;
  } vcoef_t;

  // Bernstein weights (Q1.32)
  typedef struct packed {
    logic [WT_W-1:0] b0;
    logic [WT_W-1:0] b1;
    logic [WT_W-1:0] b2;
    logic [WT_W-1:0] b3;
  } wts_t;

endpackage

/* hw/rtl/bsp_fetch.sv */
// Control point banks and parameter decode (pipeline stage 1).
module bsp_fetch #(
  parameter int SEGMENTS = 8
) (
  input  logic             clk,
  input  bsp_pkg::pipe_en_t en,
  input  logic             wr_en,
  input  logic [4:0]       wr_index,
  input  bsp_pkg::coord_t  wr_x,
  input  bsp_pkg::coord_t  wr_y,
  input  logic [23:0]      param_w,
  output bsp_pkg::tpar_t   t_o,
  output logic             clamped_o,
  output bsp_pkg::coord_t  px_o [4],
  output bsp_pkg::coord_t  py_o [4]
);
  import bsp_pkg::*;

  localparam int AW      = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int NPOINTS = 3 * SEGMENTS + 1;
  localparam logic [7:0]    SEG_LIM  = 8'(SEGMENTS);
  localparam logic [7:0]    PT_LIM   = 8'(NPOINTS);
  localparam logic [AW-1:0] SEG_LAST = AW'(SEGMENTS - 1);

  // bank j, row k holds point 3k+j
  logic [47:0] bank_mem [4][SEGMENTS];
  logic [47:0] rd_r [4];
  tpar_t       t_r;
  logic        clp_r;

  logic [8:0]    idx_mul;
  logic [3:0]    idx_q;
  logic [4:0]    idx_3q;
  logic [4:0]    idx_rem5;
  logic [1:0]    idx_rem;
  logic          in_range;
  logic          lo_ok;
  logic [3:0]    we;
  logic [AW-1:0] wa_lo;
  logic [AW-1:0] wa_hi;

  logic          w_neg;
  logic          w_over;
  logic [AW-1:0] seg_nxt;
  tpar_t         t_nxt;
  logic          clp_nxt;

  // index / 3 by reciprocal, exact for 5-bit indexes
  always_comb begin
    idx_mul  = {4'b0, wr_index} * 9'd11;
    idx_q    = idx_mul[8:5];
    idx_3q   = {1'b0, idx_q} * 5'd3;
    idx_rem5 = wr_index - idx_3q;
    idx_rem  = idx_rem5[1:0];
    in_range = {3'b0, wr_index} < PT_LIM;
    lo_ok    = {4'b0, idx_q} < SEG_LIM;
    wa_lo    = AW'(idx_q);
    wa_hi    = AW'(idx_q - 4'd1);
    we[0]    = wr_en && in_range && lo_ok && (idx_rem == 2'd0);
    we[1]    = wr_en && in_range && lo_ok && (idx_rem == 2'd1);
    we[2]    = wr_en && in_range && lo_ok && (idx_rem == 2'd2);
    we[3]    = wr_en && in_range && (idx_rem == 2'd0) && (idx_q != 4'd0);
  end

  always_comb begin
    w_neg  = param_w[23];
    w_over = !w_neg && (param_w[23:16] >= SEG_LIM);
    priority if (w_neg) begin
      seg_nxt = '0;
      t_nxt   = '0;
      clp_nxt = 1'b1;
    end else if (w_over) begin
      seg_nxt = SEG_LAST;
      t_nxt   = 17'h10000;
      clp_nxt = 1'b1;
    end else begin
      seg_nxt = AW'(param_w[23:16]);
      t_nxt   = {1'b0, param_w[15:0]};
      clp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      if (we[j]) begin
        bank_mem[j][wa_lo] <= {wr_y, wr_x};
      end
    end
    if (we[3]) begin
      bank_mem[3][wa_hi] <= {wr_y, wr_x};
    end
    if (en.st1) begin
      for (int j = 0; j < 4; j++) begin
        rd_r[j] <= bank_mem[j][seg_nxt];
      end
      t_r   <= t_nxt;
      clp_r <= clp_nxt;
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      px_o[j] = rd_r[j][23:0];
      py_o[j] = rd_r[j][47:24];
    end
  end

  assign t_o       = t_r;
  assign clamped_o = clp_r;

endmodule

/* hw/rtl/bsp_basis.sv */
// Bernstein weights and derivative coefficients from t (stages 2 to 4).
module bsp_basis (
  input  logic              clk,
  input  bsp_pkg::pipe_en_t en,
  input  bsp_pkg::tpar_t    t_i,
  output bsp_pkg::six_t     sixu_o,
  output bsp_pkg::six_t     sixt_o,
  output bsp_pkg::vcoef_t   vcoef_o,
  output bsp_pkg::wts_t     wts_o
);
  import bsp_pkg::*;

  function automatic logic [WT_W-1:0] rnd16(input logic [48:0] v);
    logic [48:0] s;
    s = v + 49'h8000;
    return s[48:16];
  endfunction

  function automatic logic [WT_W-1:0] triple(input logic [WT_W-1:0] v);
    logic [WT_W:0] s;
    s = {v, 1'b0} + {1'b0, v};
    return s[WT_W-1:0];
  endfunction

  // stage 2
  tpar_t       u_nxt;
  logic [33:0] uu_full, ut_full, tt_full;
  logic [18:0] sixu_nxt, sixt_nxt;
  tpar_t       u2_r, t2_r;
  logic [32:0] uu2_r, ut2_r, tt2_r;
  six_t        sixu2_r, sixt2_r;

  always_comb begin
    u_nxt    = 17'h10000 - t_i;
    uu_full  = {17'b0, u_nxt} * {17'b0, u_nxt};
    ut_full  = {17'b0, u_nxt} * {17'b0, t_i};
    tt_full  = {17'b0, t_i} * {17'b0, t_i};
    sixu_nxt = {u_nxt, 2'b0} + {1'b0, u_nxt, 1'b0};
    sixt_nxt = {t_i, 2'b0} + {1'b0, t_i, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en.st2) begin
      u2_r    <= u_nxt;
      t2_r    <= t_i;
      uu2_r   <= uu_full[32:0];
      ut2_r   <= ut_full[32:0];
      tt2_r   <= tt_full[32:0];
      sixu2_r <= sixu_nxt;
      sixt2_r <= sixt_nxt;
    end
  end

  // stage 3
  logic [49:0] p0_full, p1_full, p2_full, p3_full;
  logic [34:0] cm_full;
  vcoef_t      vc_nxt;
  logic [48:0] raw0_r, raw1_r, raw2_r, raw3_r;
  vcoef_t      vc3_r;

  always_comb begin
    p0_full   = {17'b0, uu2_r} * {33'b0, u2_r};
    p1_full   = {17'b0, uu2_r} * {33'b0, t2_r};
    p2_full   = {17'b0, tt2_r} * {33'b0, u2_r};
    p3_full   = {17'b0, tt2_r} * {33'b0, t2_r};
    vc_nxt.cu = {uu2_r, 1'b0} + {1'b0, uu2_r};
    cm_full   = {ut2_r, 2'b0} + {1'b0, ut2_r, 1'b0};
    vc_nxt.cm = cm_full[33:0];
    vc_nxt.ct = {tt2_r, 1'b0} + {1'b0, tt2_r};
  end

  always_ff @(posedge clk) begin
    if (en.st3) begin
      raw0_r <= p0_full[48:0];
      raw1_r <= p1_full[48:0];
      raw2_r <= p2_full[48:0];
      raw3_r <= p3_full[48:0];
      vc3_r  <= vc_nxt;
    end
  end

  // stage 4
  wts_t wts4_r;

  always_ff @(posedge clk) begin
    if (en.st4) begin
      wts4_r.b0 <= rnd16(raw0_r);
      wts4_r.b1 <= triple(rnd16(raw1_r));
      wts4_r.b2 <= triple(rnd16(raw2_r));
      wts4_r.b3 <= rnd16(raw3_r);
    end
  end

  assign sixu_o  = sixu2_r;
  assign sixt_o  = sixt2_r;
  assign vcoef_o = vc3_r;
  assign wts_o   = wts4_r;

endmodule

/* hw/rtl/bsp_axis.sv */
// One coordinate axis: position, velocity and acceleration (stages 2 to 6).
module bsp_axis (
  input  logic              clk,
  input  bsp_pkg::pipe_en_t en,
  input  bsp_pkg::coord_t   p_i [4],
  input  bsp_pkg::six_t     sixu_i,
  input  bsp_pkg::six_t     sixt_i,
  input  bsp_pkg::vcoef_t   vcoef_i,
  input  bsp_pkg::wts_t     wts_i,
  output bsp_pkg::res_t     pos_o,
  output bsp_pkg::res_t     vel_o,
  output bsp_pkg::res_t     acc_o
);
  import bsp_pkg::*;

  // stage 2: differences
  logic signed [24:0] d2_r [3];
  logic signed [25:0] e2_r [2];
  coord_t             p2_r [4];

  always_ff @(posedge clk) begin
    if (en.st2) begin
      for (int i = 0; i < 3; i++) begin
        d2_r[i] <= {p_i[i+1][23], p_i[i+1]} - {p_i[i][23], p_i[i]};
      end
      for (int i = 0; i < 2; i++) begin
        e2_r[i] <= {{2{p_i[i+2][23]}}, p_i[i+2]} - {p_i[i+1][23], p_i[i+1], 1'b0}
                 + {{2{p_i[i][23]}}, p_i[i]};
      end
      for (int i = 0; i < 4; i++) begin
        p2_r[i] <= p_i[i];
      end
    end
  end

  // stage 3: acceleration products
  logic signed [45:0] ea3_r, eb3_r;
  logic signed [24:0] d3_r [3];
  coord_t             p3_r [4];

  always_ff @(posedge clk) begin
    if (en.st3) begin
      ea3_r <= $signed({1'b0, sixu_i}) * e2_r[0];
      eb3_r <= $signed({1'b0, sixt_i}) * e2_r[1];
      d3_r  <= d2_r;
      p3_r  <= p2_r;
    end
  end

  // stage 4: acceleration sum, velocity products
  logic signed [46:0] acc_sum;
  logic signed [59:0] v4_r [3];
  res_t               acc4_r;
  coord_t             p4_r [4];

  always_comb begin
    acc_sum = {ea3_r[45], ea3_r} + {eb3_r[45], eb3_r} + 47'sh8000;
  end

  always_ff @(posedge clk) begin
    if (en.st4) begin
      acc4_r  <= {acc_sum[46], acc_sum[46:16]};
      v4_r[0] <= $signed({1'b0, vcoef_i.cu}) * d3_r[0];
      v4_r[1] <= $signed({1'b0, vcoef_i.cm}) * d3_r[1];
      v4_r[2] <= $signed({1'b0, vcoef_i.ct}) * d3_r[2];
      p4_r    <= p3_r;
    end
  end

  // stage 5: velocity sum, position products
  logic signed [61:0] vel_sum;
  logic signed [57:0] q5_r [4];
  res_t               vel5_r, acc5_r;

  always_comb begin
    vel_sum = {{2{v4_r[0][59]}}, v4_r[0]} + {{2{v4_r[1][59]}}, v4_r[1]}
            + {{2{v4_r[2][59]}}, v4_r[2]} + 62'sh8000_0000;
  end

  always_ff @(posedge clk) begin
    if (en.st5) begin
      vel5_r  <= {{2{vel_sum[61]}}, vel_sum[61:32]};
      acc5_r  <= acc4_r;
      q5_r[0] <= $signed({1'b0, wts_i.b0}) * p4_r[0];
      q5_r[1] <= $signed({1'b0, wts_i.b1}) * p4_r[1];
      q5_r[2] <= $signed({1'b0, wts_i.b2}) * p4_r[2];
      q5_r[3] <= $signed({1'b0, wts_i.b3}) * p4_r[3];
    end
  end

  // stage 6: position sum
  logic signed [59:0] pos_sum;
  res_t               pos6_r, vel6_r, acc6_r;

  always_comb begin
    pos_sum = {{2{q5_r[0][57]}}, q5_r[0]} + {{2{q5_r[1][57]}}, q5_r[1]}
            + {{2{q5_r[2][57]}}, q5_r[2]} + {{2{q5_r[3][57]}}, q5_r[3]}
            + 60'sh8000_0000;
  end

  always_ff @(posedge clk) begin
    if (en.st6) begin
      pos6_r <= {{4{pos_sum[59]}}, pos_sum[59:32]};
      vel6_r <= vel5_r;
      acc6_r <= acc5_r;
    end
  end

  assign pos_o = pos6_r;
  assign vel_o = vel6_r;
  assign acc_o = acc6_r;

endmodule

/* hw/rtl/bezier_spline_eval_2d.sv */
// Top level of the 2D piecewise cubic Bezier spline evaluator.
//
//   port group  dir  beat contents
//   in_*        in   load one control point (tuser=0) or evaluate at w (tuser=1)
//   out_*       out  position, velocity, acceleration, clamp flag
//
// Six register stages; an evaluate beat passes stages 1 to 6 to reach out_*,
// one beat per cycle sustained while out_tready is high. Load beats write the
// point banks at the edge they are taken and make no output beat. Each stage
// has its own valid; out_tready low holds the full stages and empty stages still
// fill. Reset clears valids only; control points read undefined until loaded.
module bezier_spline_eval_2d #(
  parameter int SEGMENTS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,  // point_index, point_x, point_y, param_w, pad
  input  logic         in_tuser,  // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata, // pos_x, pos_y, vel_x, vel_y, acc_x, acc_y
  output logic         out_tuser  // clamped
);
  import bsp_pkg::*;

  logic [6:1] vld_r;
  logic [6:1] vld_nxt;
  logic [6:1] rdy;
  logic [6:2] clp_r;
  pipe_en_t   en;

  logic   wr_en;
  tpar_t  t1;
  logic   clp1;
  coord_t px1 [4];
  coord_t py1 [4];
  six_t   sixu, sixt;
  vcoef_t vcoef;
  wts_t   wts;
  res_t   pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;

  always_comb begin
    rdy[6] = !vld_r[6] || out_tready;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[1] = in_tvalid && (in_tuser == MODE_EVAL);
    for (int k = 2; k <= 6; k++) begin
      vld_nxt[k] = vld_r[k-1];
    end
  end

  assign en.st1 = rdy[1];
  assign en.st2 = rdy[2];
  assign en.st3 = rdy[3];
  assign en.st4 = rdy[4];
  assign en.st5 = rdy[5];
  assign en.st6 = rdy[6];

  assign in_tready = rdy[1];
  assign wr_en     = in_tvalid && in_tready && (in_tuser == MODE_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 1; k <= 6; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      clp_r[2] <= clp1;
    end
    for (int k = 3; k <= 6; k++) begin
      if (rdy[k]) begin
        clp_r[k] <= clp_r[k-1];
      end
    end
  end

  bsp_fetch #(
    .SEGMENTS(SEGMENTS)
  ) u_fetch (
    .clk      (clk),
    .en       (en),
    .wr_en    (wr_en),
    .wr_index (in_tdata[4:0]),
    .wr_x     (in_tdata[28:5]),
    .wr_y     (in_tdata[52:29]),
    .param_w  (in_tdata[76:53]),
    .t_o      (t1),
    .clamped_o(clp1),
    .px_o     (px1),
    .py_o     (py1)
  );

  bsp_basis u_basis (
    .clk    (clk),
    .en     (en),
    .t_i    (t1),
    .sixu_o (sixu),
    .sixt_o (sixt),
    .vcoef_o(vcoef),
    .wts_o  (wts)
  );

  bsp_axis u_axis_x (
    .clk    (clk),
    .en     (en),
    .p_i    (px1),
    .sixu_i (sixu),
    .sixt_i (sixt),
    .vcoef_i(vcoef),
    .wts_i  (wts),
    .pos_o  (pos_x),
    .vel_o  (vel_x),
    .acc_o  (acc_x)
  );

  bsp_axis u_axis_y (
    .clk    (clk),
    .en     (en),
    .p_i    (py1),
    .sixu_i (sixu),
    .sixt_i (sixt),
    .vcoef_i(vcoef),
    .wts_i  (wts),
    .pos_o  (pos_y),
    .vel_o  (vel_y),
    .acc_o  (acc_y)
  );

  assign out_tvalid = vld_r[6];
  assign out_tuser  = clp_r[6];
  assign out_tdata  = {acc_y, acc_x, vel_y, vel_x, pos_y, pos_x};

endmodule
